### src/otq_pkg.sv
`timescale 1ns / 1ps
package otq_pkg;

	// Fixed field widths and upper bounds of the parameter ranges
	localparam int ID_W        = 32;
	localparam int OWNER_W     = 8;
	localparam int STAMP_W     = 32;
	localparam int COUNT_OUT_W = 7;
	localparam int TIME_W_MAX  = 64;
	localparam int IDX_W_MAX   = 6;
	localparam int CNT_W_MAX   = 7;

	localparam int TIMER_SLOTS_DEF = 16;
	localparam int TIME_BITS_DEF   = 48;
	localparam int MAX_RESULTS     = 16;
	localparam int NRES_W          = $clog2(MAX_RESULTS + 1);

	typedef enum logic [1:0] {
		OP_SET          = 2'd0,
		OP_CANCEL_ID    = 2'd1,
		OP_CANCEL_OWNER = 2'd2,
		OP_TICK         = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_SET     = 2'd0,
		KIND_CANCEL  = 2'd1,
		KIND_OWNER   = 2'd2,
		KIND_EXPIRED = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		op_t                opcode;
		logic [OWNER_W-1:0] owner;
		logic [31:0]        delay_ticks;
		logic [ID_W-1:0]    cancel_id;
	} cmd_t;

	typedef struct packed {
		kind_t                  kind;
		logic [ID_W-1:0]        timer_id;
		logic [OWNER_W-1:0]     timer_owner;
		logic                   ok;
		logic [COUNT_OUT_W-1:0] removed_count;
		logic                   last;
	} result_t;

	// Search record handed from cell to cell during one sweep
	typedef struct packed {
		logic                  act;
		logic                  hit;
		logic [IDX_W_MAX-1:0]  idx;
		logic [TIME_W_MAX-1:0] expiry;
		logic [STAMP_W-1:0]    age;
		logic [ID_W-1:0]       id;
		logic [OWNER_W-1:0]    owner;
		logic                  free_ok;
		logic [IDX_W_MAX-1:0]  free_idx;
		logic                  used;
		logic [CNT_W_MAX-1:0]  cnt;
	} pass_t;

	// Broadcast from the controller to every cell
	typedef struct packed {
		op_t                   op;
		logic [ID_W-1:0]       key_id;
		logic [OWNER_W-1:0]    key_owner;
		logic [TIME_W_MAX-1:0] now;
		logic [STAMP_W-1:0]    stamp;
		logic                  wr_en;
		logic                  clr_en;
		logic [IDX_W_MAX-1:0]  idx;
		logic [TIME_W_MAX-1:0] wr_expiry;
	} bus_t;

	// Next id after x, skipping zero
	function automatic logic [ID_W-1:0] next_id(input logic [ID_W-1:0] x);
		logic [ID_W-1:0] y;
		y = x + ID_W'(1);
		if (y == '0) begin
			y = ID_W'(1);
		end
		return y;
	endfunction

endpackage

### src/otq_cell.sv
`timescale 1ns / 1ps
module otq_cell import otq_pkg::*; #(
	parameter int TIME_BITS = TIME_BITS_DEF,
	parameter int INDEX     = 0
) (
	input  logic  clk,
	input  logic  arst_n,
	input  bus_t  bus,
	input  pass_t pass_in,
	output pass_t pass_out
);

	logic                   valid_q;
	logic [ID_W-1:0]        id_q;
	logic [OWNER_W-1:0]     owner_q;
	logic [TIME_BITS-1:0]   expiry_q;
	logic [STAMP_W-1:0]     stamp_q;
	pass_t                  pass_q;

	pass_t                  p;
	logic                   clear_self;
	logic [TIME_W_MAX-1:0]  exp_w;
	logic [STAMP_W-1:0]     age_w;
	logic                   mine;

	assign exp_w = TIME_W_MAX'(expiry_q);
	assign age_w = bus.stamp - stamp_q;
	assign mine  = (bus.idx == IDX_W_MAX'(INDEX));

	// Merge this slot into the passing record
	always_comb begin
		p = pass_in;
		clear_self = 1'b0;
		if (pass_in.act) begin
			case (bus.op)
				OP_SET: begin
					if (!valid_q && !pass_in.free_ok) begin
						p.free_ok  = 1'b1;
						p.free_idx = IDX_W_MAX'(INDEX);
					end
					if (valid_q && id_q == bus.key_id) begin
						p.used = 1'b1;
					end
				end
				OP_CANCEL_ID: begin
					if (valid_q && id_q == bus.key_id && bus.key_id != '0 && !pass_in.hit) begin
						p.hit      = 1'b1;
						clear_self = 1'b1;
					end
				end
				OP_CANCEL_OWNER: begin
					if (valid_q && owner_q == bus.key_owner) begin
						p.cnt      = pass_in.cnt + CNT_W_MAX'(1);
						clear_self = 1'b1;
					end
				end
				OP_TICK: begin
					if (valid_q && exp_w <= bus.now && (!pass_in.hit || exp_w < pass_in.expiry ||
						(exp_w == pass_in.expiry && age_w > pass_in.age))) begin
						p.hit    = 1'b1;
						p.idx    = IDX_W_MAX'(INDEX);
						p.expiry = exp_w;
						p.age    = age_w;
						p.id     = id_q;
						p.owner  = owner_q;
					end
				end
				default: begin
					p = pass_in;
				end
			endcase
		end
	end

	// Hand the record to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_q <= '0;
		end else begin
			pass_q <= p;
		end
	end

	assign pass_out = pass_q;

	// Hold the slot; load on write, drop on clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (bus.wr_en && mine) begin
			valid_q <= 1'b1;
		end else if (clear_self || (bus.clr_en && mine)) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (bus.wr_en && mine) begin
			id_q     <= bus.key_id;
			owner_q  <= bus.key_owner;
			expiry_q <= bus.wr_expiry[TIME_BITS-1:0];
			stamp_q  <= bus.stamp;
		end
	end

endmodule

### src/ordered_timer_queue.sv
`timescale 1ns / 1ps
// Ordered one-shot timer queue.
// Command channel: drive cmd and raise start; the beat is taken on a clock
// edge where start is high and busy is low. busy stays high until the cycle
// that shows the last result of that command, so the next command can be
// taken at the edge that ends that cycle.
// Result channel: each result beat sits on result for one cycle with
// result_valid high; the receiver cannot stall and must take it then.
// Set, cancel and owner cancel give one beat; tick gives zero to
// MAX_RESULTS expired-timer beats, the final one carrying last.
// Searches: every search is one sweep of a record down the row of slot cells.
// Cancel and owner cancel take one sweep; set takes one sweep per id
// candidate tried (at most TIMER_SLOTS, one on a full table); tick takes one
// sweep per expired timer plus a final empty one, or MAX_RESULTS sweeps and
// a pass through the flush state when the limit is hit.
// Reset empties every slot and clears time, id counter and set counter;
// no clearing pass is needed.
module ordered_timer_queue import otq_pkg::*; #(
	parameter int TIMER_SLOTS = TIMER_SLOTS_DEF,
	parameter int TIME_BITS   = TIME_BITS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  cmd_t    cmd,
	output logic    busy,
	output logic    result_valid,
	output result_t result
);

	localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

	state_t               state_q, state_d;
	op_t                  op_q, op_d;
	logic [OWNER_W-1:0]   owner_q, owner_d;
	logic [ID_W-1:0]      key_id_q, key_id_d;
	logic [TIME_BITS-1:0] now_q, now_d;
	logic [TIME_BITS-1:0] expiry_q, expiry_d;
	logic [STAMP_W-1:0]   stamp_q, stamp_d;
	logic [ID_W-1:0]      id_ctr_q, id_ctr_d;
	logic [NRES_W-1:0]    nres_q, nres_d;
	logic                 held_v_q, held_v_d;
	logic [ID_W-1:0]      held_id_q, held_id_d;
	logic [OWNER_W-1:0]   held_own_q, held_own_d;
	logic                 launch_q, launch_d;
	logic                 rv_q, rv_d;
	result_t              res_q, res_d;

	bus_t                 bus;
	pass_t                chain [TIMER_SLOTS+1];
	pass_t                tail;
	logic [TIME_BITS:0]   sum_w;

	// Feed a fresh record into the first cell
	always_comb begin
		chain[0]     = '0;
		chain[0].act = launch_q;
	end

	genvar g;
	generate
		for (g = 0; g < TIMER_SLOTS; g++) begin : g_cell
			otq_cell #(
				.TIME_BITS(TIME_BITS),
				.INDEX    (g)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.bus     (bus),
				.pass_in (chain[g]),
				.pass_out(chain[g+1])
			);
		end
	endgenerate

	assign tail  = chain[TIMER_SLOTS];
	assign sum_w = {1'b0, now_q} + (TIME_BITS+1)'(cmd.delay_ticks);

	// Sequence commands and build result beats
	always_comb begin
		state_d    = state_q;
		op_d       = op_q;
		owner_d    = owner_q;
		key_id_d   = key_id_q;
		now_d      = now_q;
		expiry_d   = expiry_q;
		stamp_d    = stamp_q;
		id_ctr_d   = id_ctr_q;
		nres_d     = nres_q;
		held_v_d   = held_v_q;
		held_id_d  = held_id_q;
		held_own_d = held_own_q;
		launch_d   = 1'b0;
		rv_d       = 1'b0;
		res_d      = res_q;

		bus           = '0;
		bus.op        = op_q;
		bus.key_id    = key_id_q;
		bus.key_owner = owner_q;
		bus.now       = TIME_W_MAX'(now_q);
		bus.stamp     = stamp_q;
		bus.wr_expiry = TIME_W_MAX'(expiry_q);

		case (state_q)
			ST_IDLE: begin
				if (start) begin
					op_d     = cmd.opcode;
					owner_d  = cmd.owner;
					nres_d   = '0;
					held_v_d = 1'b0;
					launch_d = 1'b1;
					state_d  = ST_SCAN;
					if (cmd.opcode == OP_SET) begin
						key_id_d = next_id(id_ctr_q);
					end else begin
						key_id_d = cmd.cancel_id;
					end
					expiry_d = sum_w[TIME_BITS] ? TIME_MAX : sum_w[TIME_BITS-1:0];
					if (cmd.opcode == OP_TICK && now_q != TIME_MAX) begin
						now_d = now_q + TIME_BITS'(1);
					end
				end
			end
			ST_SCAN: begin
				if (tail.act) begin
					res_d = '0;
					case (op_q)
						OP_SET: begin
							res_d.kind = KIND_SET;
							res_d.last = 1'b1;
							if (!tail.free_ok) begin
								rv_d    = 1'b1;
								state_d = ST_IDLE;
							end else if (tail.used) begin
								key_id_d = next_id(key_id_q);
								launch_d = 1'b1;
							end else begin
								bus.wr_en      = 1'b1;
								bus.idx        = tail.free_idx;
								id_ctr_d       = key_id_q;
								stamp_d        = stamp_q + STAMP_W'(1);
								res_d.timer_id = key_id_q;
								res_d.ok       = 1'b1;
								rv_d           = 1'b1;
								state_d        = ST_IDLE;
							end
						end
						OP_CANCEL_ID: begin
							res_d.kind = KIND_CANCEL;
							res_d.ok   = tail.hit;
							res_d.last = 1'b1;
							rv_d       = 1'b1;
							state_d    = ST_IDLE;
						end
						OP_CANCEL_OWNER: begin
							res_d.kind          = KIND_OWNER;
							res_d.ok            = (tail.cnt != '0);
							res_d.removed_count = COUNT_OUT_W'(tail.cnt);
							res_d.last          = 1'b1;
							rv_d                = 1'b1;
							state_d             = ST_IDLE;
						end
						OP_TICK: begin
							res_d.kind        = KIND_EXPIRED;
							res_d.timer_id    = held_id_q;
							res_d.timer_owner = held_own_q;
							if (tail.hit) begin
								bus.clr_en = 1'b1;
								bus.idx    = tail.idx;
								rv_d       = held_v_q;
								held_v_d   = 1'b1;
								held_id_d  = tail.id;
								held_own_d = tail.owner;
								nres_d     = nres_q + NRES_W'(1);
								if (nres_q + NRES_W'(1) == NRES_W'(MAX_RESULTS)) begin
									state_d = ST_FLUSH;
								end else begin
									launch_d = 1'b1;
								end
							end else begin
								res_d.last = 1'b1;
								rv_d       = held_v_q;
								state_d    = ST_IDLE;
							end
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_FLUSH: begin
				res_d             = '0;
				res_d.kind        = KIND_EXPIRED;
				res_d.timer_id    = held_id_q;
				res_d.timer_owner = held_own_q;
				res_d.last        = 1'b1;
				rv_d              = 1'b1;
				state_d           = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			op_q     <= OP_SET;
			now_q    <= '0;
			stamp_q  <= '0;
			id_ctr_q <= '0;
			nres_q   <= '0;
			held_v_q <= 1'b0;
			launch_q <= 1'b0;
			rv_q     <= 1'b0;
		end else begin
			state_q  <= state_d;
			op_q     <= op_d;
			now_q    <= now_d;
			stamp_q  <= stamp_d;
			id_ctr_q <= id_ctr_d;
			nres_q   <= nres_d;
			held_v_q <= held_v_d;
			launch_q <= launch_d;
			rv_q     <= rv_d;
		end
	end

	// Hold payload
	always_ff @(posedge clk) begin
		owner_q    <= owner_d;
		key_id_q   <= key_id_d;
		expiry_q   <= expiry_d;
		held_id_q  <= held_id_d;
		held_own_q <= held_own_d;
		res_q      <= res_d;
	end

	assign busy         = (state_q != ST_IDLE);
	assign result_valid = rv_q;
	assign result       = res_q;

endmodule
